// ----- sv/pgw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgw_pkg
// Shared types and codes of the placement grid window table: operation,
// status and direction codes, register indexes, sequencer states and the
// configuration and result bundles.
// ----------------------------------------------------------------------------
package pgw_pkg;

    localparam int NUM_PIECES = 256;
    localparam int CFG_AW     = 4;

    localparam logic [8:0] EMPTY_PIECE = 9'h1FF;

    // operation codes
    localparam logic [2:0] OP_PLACE     = 3'd0;
    localparam logic [2:0] OP_LOCATE    = 3'd1;
    localparam logic [2:0] OP_READ      = 3'd2;
    localparam logic [2:0] OP_NBR_CELL  = 3'd3;
    localparam logic [2:0] OP_NBR_PIECE = 3'd4;
    localparam logic [2:0] OP_SWAP      = 3'd5;

    // status codes
    localparam logic [2:0] STAT_OK         = 3'd0;
    localparam logic [2:0] STAT_ALREADY    = 3'd1;
    localparam logic [2:0] STAT_OUTSIDE    = 3'd2;
    localparam logic [2:0] STAT_OCCUPIED   = 3'd3;
    localparam logic [2:0] STAT_NOT_PLACED = 3'd4;
    localparam logic [2:0] STAT_OFF_GRID   = 3'd5;

    // neighbour directions
    localparam logic [1:0] DIR_LEFT  = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_UP    = 2'd2;
    localparam logic [1:0] DIR_DOWN  = 2'd3;

    // configuration register indexes (byte address / 4)
    localparam logic [1:0] REG_ROWS  = 2'd0;
    localparam logic [1:0] REG_COLS  = 2'd1;
    localparam logic [1:0] REG_FIXED = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_PLACE,
        S_LOC,
        S_PLOAD,
        S_NBR,
        S_CELL,
        S_SW1,
        S_SW2,
        S_SW3
    } pgw_state_t;

    // effective (saturated) puzzle size and window mode
    typedef struct packed {
        logic [4:0] rows;
        logic [4:0] cols;
        logic       fixed;
    } cfg_t;

    typedef struct packed {
        logic [2:0]        status;
        logic signed [8:0] found_piece;
        logic [4:0]        found_row;
        logic [4:0]        found_col;
        logic [8:0]        placed_count;
        logic [4:0]        box_top;
        logic [4:0]        box_left;
        logic [4:0]        box_bottom;
        logic [4:0]        box_right;
    } res_t;

endpackage

// ----- sv/pgw_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgw_ram
// Single-port synchronous RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module pgw_ram #(
    parameter int DW = 9,
    parameter int AW = 10
) (
    input  logic          clk,
    input  logic          we,
    input  logic          re,
    input  logic [AW-1:0] addr,
    input  logic [DW-1:0] wdata,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem_reg [2**AW];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/pgw_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgw_regs
// APB configuration registers: puzzle rows, puzzle columns and window mode.
// Hands the saturated puzzle size to the core.
// ----------------------------------------------------------------------------
module pgw_regs
    import pgw_pkg::*;
#(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [4:0] rows_reg;
    logic [4:0] cols_reg;
    logic       fixed_reg;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg  <= 5'd16;
            cols_reg  <= 5'd16;
            fixed_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_ROWS:  rows_reg  <= pwdata[4:0];
                REG_COLS:  cols_reg  <= pwdata[4:0];
                REG_FIXED: fixed_reg <= pwdata[0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_ROWS:  prdata = {27'd0, rows_reg};
            REG_COLS:  prdata = {27'd0, cols_reg};
            REG_FIXED: prdata = {31'd0, fixed_reg};
            default:   prdata = 32'd0;
        endcase
    end

    // clamp the puzzle size to 1..MAX
    always_comb
    begin
        if (rows_reg == 5'd0)
            cfg.rows = 5'd1;
        else if (32'(rows_reg) > MAX_ROWS)
            cfg.rows = 5'(MAX_ROWS);
        else
            cfg.rows = rows_reg;

        if (cols_reg == 5'd0)
            cfg.cols = 5'd1;
        else if (32'(cols_reg) > MAX_COLS)
            cfg.cols = 5'(MAX_COLS);
        else
            cfg.cols = cols_reg;

        cfg.fixed = fixed_reg;
    end

endmodule

// ----- sv/pgw_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgw_core
// Request sequencer: clears the grid RAM after reset, then runs each request
// as a short read-check-write sequence on the grid RAM and the piece map RAM.
// Holds piece valid bits, placed count and bounding box.
// ----------------------------------------------------------------------------
module pgw_core
    import pgw_pkg::*;
#(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfg_t                 cfg,
    input  logic                 start,
    output logic                 busy,
    input  logic [2:0]           op,
    input  logic [4:0]           row,
    input  logic [4:0]           col,
    input  logic [7:0]           piece,
    input  logic [7:0]           other_piece,
    input  logic [1:0]           direction,
    output logic                 done,
    output res_t                 res,
    output logic                 grid_we,
    output logic                 grid_re,
    output logic [$clog2(2*MAX_ROWS)+$clog2(2*MAX_COLS)-1:0] grid_addr,
    output logic [8:0]           grid_wdata,
    input  logic [8:0]           grid_rdata,
    output logic                 piece_we,
    output logic                 piece_re,
    output logic [7:0]           piece_addr,
    output logic [$clog2(2*MAX_ROWS)+$clog2(2*MAX_COLS)-1:0] piece_wdata,
    input  logic [$clog2(2*MAX_ROWS)+$clog2(2*MAX_COLS)-1:0] piece_rdata
);

    localparam int RW  = $clog2(2*MAX_ROWS);
    localparam int CW  = $clog2(2*MAX_COLS);
    localparam int GAW = RW + CW;

    pgw_state_t state_reg, state_next;

    logic [GAW-1:0]        clr_addr_reg, clr_addr_next;
    logic [2:0]            op_reg, op_next;
    logic [7:0]            pc_reg, pc_next;
    logic [7:0]            pc2_reg, pc2_next;
    logic [1:0]            dir_reg, dir_next;
    logic [5:0]            cur_row_reg, cur_row_next;
    logic [5:0]            cur_col_reg, cur_col_next;
    logic [NUM_PIECES-1:0] valid_reg, valid_next;
    logic [8:0]            count_reg, count_next;
    logic [4:0]            top_reg, top_next;
    logic [4:0]            left_reg, left_next;
    logic [4:0]            bottom_reg, bottom_next;
    logic [4:0]            right_reg, right_next;
    logic                  done_reg, done_next;
    logic [2:0]            status_reg, status_next;
    logic [8:0]            found_reg, found_next;
    logic [4:0]            frow_reg, frow_next;
    logic [4:0]            fcol_reg, fcol_next;

    logic [5:0] nbr_row;
    logic [5:0] nbr_col;
    logic [9:0] area;
    logic [5:0] map_row;
    logic [5:0] map_col;

    function automatic logic [GAW-1:0] cell_addr(input logic [5:0] r, input logic [5:0] c);
        cell_addr = {RW'(r), CW'(c)};
    endfunction

    function automatic logic on_grid(input logic [5:0] r, input logic [5:0] c);
        on_grid = (r < {cfg.rows, 1'b0}) && (c < {cfg.cols, 1'b0});
    endfunction

    function automatic logic in_window(input logic [5:0] r, input logic [5:0] c);
        logic [5:0] d_top;
        logic [5:0] d_bot;
        logic [5:0] d_left;
        logic [5:0] d_right;
        d_top   = (r >= {1'b0, top_reg})    ? r - {1'b0, top_reg}    : {1'b0, top_reg} - r;
        d_bot   = (r >= {1'b0, bottom_reg}) ? r - {1'b0, bottom_reg} : {1'b0, bottom_reg} - r;
        d_left  = (c >= {1'b0, left_reg})   ? c - {1'b0, left_reg}   : {1'b0, left_reg} - c;
        d_right = (c >= {1'b0, right_reg})  ? c - {1'b0, right_reg}  : {1'b0, right_reg} - c;
        if (cfg.fixed)
            in_window = (r != 6'd0) && (r <= {1'b0, cfg.rows})
                     && (c != 6'd0) && (c <= {1'b0, cfg.cols});
        else if (count_reg == 9'd0)
            in_window = 1'b1;
        else
            in_window = (d_top < {1'b0, cfg.rows}) && (d_bot < {1'b0, cfg.rows})
                     && (d_left < {1'b0, cfg.cols}) && (d_right < {1'b0, cfg.cols});
    endfunction

    function automatic logic is_placed(input logic [7:0] p);
        is_placed = ({2'b00, p} < area) && valid_reg[p];
    endfunction

    assign area    = {5'd0, cfg.rows} * {5'd0, cfg.cols};
    assign map_row = 6'(piece_rdata[GAW-1:CW]);
    assign map_col = 6'(piece_rdata[CW-1:0]);
    assign busy    = (state_reg != S_IDLE);
    assign done    = done_reg;

    always_comb
    begin
        nbr_row = cur_row_reg;
        nbr_col = cur_col_reg;
        case (dir_reg)
            DIR_LEFT:  nbr_col = cur_col_reg - 6'd1;
            DIR_RIGHT: nbr_col = cur_col_reg + 6'd1;
            DIR_UP:    nbr_row = cur_row_reg - 6'd1;
            DIR_DOWN:  nbr_row = cur_row_reg + 6'd1;
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            valid_reg    <= '0;
            count_reg    <= 9'd0;
            top_reg      <= 5'd0;
            left_reg     <= 5'd0;
            bottom_reg   <= 5'd0;
            right_reg    <= 5'd0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            valid_reg    <= valid_next;
            count_reg    <= count_next;
            top_reg      <= top_next;
            left_reg     <= left_next;
            bottom_reg   <= bottom_next;
            right_reg    <= right_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        pc_reg      <= pc_next;
        pc2_reg     <= pc2_next;
        dir_reg     <= dir_next;
        cur_row_reg <= cur_row_next;
        cur_col_reg <= cur_col_next;
        status_reg  <= status_next;
        found_reg   <= found_next;
        frow_reg    <= frow_next;
        fcol_reg    <= fcol_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        op_next       = op_reg;
        pc_next       = pc_reg;
        pc2_next      = pc2_reg;
        dir_next      = dir_reg;
        cur_row_next  = cur_row_reg;
        cur_col_next  = cur_col_reg;
        valid_next    = valid_reg;
        count_next    = count_reg;
        top_next      = top_reg;
        left_next     = left_reg;
        bottom_next   = bottom_reg;
        right_next    = right_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        found_next    = found_reg;
        frow_next     = frow_reg;
        fcol_next     = fcol_reg;

        grid_we     = 1'b0;
        grid_re     = 1'b0;
        grid_addr   = cell_addr(cur_row_reg, cur_col_reg);
        grid_wdata  = EMPTY_PIECE;
        piece_we    = 1'b0;
        piece_re    = 1'b0;
        piece_addr  = pc_reg;
        piece_wdata = {RW'(cur_row_reg), CW'(cur_col_reg)};

        case (state_reg)
            S_CLEAR:
            begin
                grid_we       = 1'b1;
                grid_addr     = clr_addr_reg;
                clr_addr_next = clr_addr_reg + GAW'(1);
                if (&clr_addr_reg)
                    state_next = S_IDLE;
            end

            S_IDLE:
            begin
                if (start)
                begin
                    op_next      = op;
                    pc_next      = piece;
                    pc2_next     = other_piece;
                    dir_next     = direction;
                    cur_row_next = {1'b0, row};
                    cur_col_next = {1'b0, col};
                    status_next  = STAT_OK;
                    found_next   = EMPTY_PIECE;
                    frow_next    = 5'd0;
                    fcol_next    = 5'd0;
                    state_next   = S_EXEC;
                end
            end

            S_EXEC:
            begin
                // by default the request ends here
                state_next = S_IDLE;
                done_next  = 1'b1;
                case (op_reg)
                    OP_PLACE:
                    begin
                        if ({2'b00, pc_reg} >= area)
                            status_next = STAT_NOT_PLACED;
                        else if (valid_reg[pc_reg])
                            status_next = STAT_ALREADY;
                        else if (!on_grid(cur_row_reg, cur_col_reg))
                            status_next = STAT_OFF_GRID;
                        else if (!in_window(cur_row_reg, cur_col_reg))
                            status_next = STAT_OUTSIDE;
                        else
                        begin
                            grid_re    = 1'b1;
                            state_next = S_PLACE;
                            done_next  = 1'b0;
                        end
                    end
                    OP_LOCATE, OP_NBR_PIECE:
                    begin
                        if (!is_placed(pc_reg))
                            status_next = STAT_NOT_PLACED;
                        else
                        begin
                            piece_re   = 1'b1;
                            state_next = (op_reg == OP_LOCATE) ? S_LOC : S_PLOAD;
                            done_next  = 1'b0;
                        end
                    end
                    OP_READ:
                    begin
                        if (!on_grid(cur_row_reg, cur_col_reg))
                            status_next = STAT_OFF_GRID;
                        else if (!in_window(cur_row_reg, cur_col_reg))
                            status_next = STAT_OUTSIDE;
                        else
                        begin
                            grid_re    = 1'b1;
                            state_next = S_CELL;
                            done_next  = 1'b0;
                        end
                    end
                    OP_NBR_CELL:
                    begin
                        state_next = S_NBR;
                        done_next  = 1'b0;
                    end
                    OP_SWAP:
                    begin
                        if (!is_placed(pc_reg) || !is_placed(pc2_reg))
                            status_next = STAT_NOT_PLACED;
                        else if (pc_reg != pc2_reg)
                        begin
                            piece_re   = 1'b1;
                            state_next = S_SW1;
                            done_next  = 1'b0;
                        end
                    end
                    default: ;
                endcase
            end

            S_PLACE:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                if (grid_rdata != EMPTY_PIECE)
                    status_next = STAT_OCCUPIED;
                else
                begin
                    grid_we            = 1'b1;
                    grid_wdata         = {1'b0, pc_reg};
                    piece_we           = 1'b1;
                    valid_next[pc_reg] = 1'b1;
                    count_next         = count_reg + 9'd1;
                    if (!cfg.fixed)
                    begin
                        if (count_reg == 9'd0)
                        begin
                            top_next    = cur_row_reg[4:0];
                            bottom_next = cur_row_reg[4:0];
                            left_next   = cur_col_reg[4:0];
                            right_next  = cur_col_reg[4:0];
                        end
                        else
                        begin
                            if (cur_row_reg[4:0] < top_reg)    top_next    = cur_row_reg[4:0];
                            if (cur_row_reg[4:0] > bottom_reg) bottom_next = cur_row_reg[4:0];
                            if (cur_col_reg[4:0] < left_reg)   left_next   = cur_col_reg[4:0];
                            if (cur_col_reg[4:0] > right_reg)  right_next  = cur_col_reg[4:0];
                        end
                    end
                    found_next = {1'b0, pc_reg};
                    frow_next  = cur_row_reg[4:0];
                    fcol_next  = cur_col_reg[4:0];
                end
            end

            S_LOC:
            begin
                found_next = {1'b0, pc_reg};
                frow_next  = map_row[4:0];
                fcol_next  = map_col[4:0];
                state_next = S_IDLE;
                done_next  = 1'b1;
            end

            S_PLOAD:
            begin
                cur_row_next = map_row;
                cur_col_next = map_col;
                state_next   = S_NBR;
            end

            S_NBR:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                if (!on_grid(cur_row_reg, cur_col_reg))
                    status_next = STAT_OFF_GRID;
                else if (!in_window(cur_row_reg, cur_col_reg))
                    status_next = STAT_OUTSIDE;
                else if (!on_grid(nbr_row, nbr_col))
                    status_next = STAT_OFF_GRID;
                else if (!in_window(nbr_row, nbr_col))
                    status_next = STAT_OUTSIDE;
                else
                begin
                    grid_re      = 1'b1;
                    grid_addr    = cell_addr(nbr_row, nbr_col);
                    cur_row_next = nbr_row;
                    cur_col_next = nbr_col;
                    state_next   = S_CELL;
                    done_next    = 1'b0;
                end
            end

            S_CELL:
            begin
                found_next = grid_rdata;
                frow_next  = cur_row_reg[4:0];
                fcol_next  = cur_col_reg[4:0];
                state_next = S_IDLE;
                done_next  = 1'b1;
            end

            S_SW1:
            begin
                // hold cell of the first piece, fetch cell of the second
                cur_row_next = map_row;
                cur_col_next = map_col;
                piece_re     = 1'b1;
                piece_addr   = pc2_reg;
                state_next   = S_SW2;
            end

            S_SW2:
            begin
                // grid holds each placed piece at its mapped cell, so no grid read
                grid_we      = 1'b1;
                grid_wdata   = {1'b0, pc2_reg};
                piece_we     = 1'b1;
                piece_addr   = pc2_reg;
                cur_row_next = map_row;
                cur_col_next = map_col;
                state_next   = S_SW3;
            end

            S_SW3:
            begin
                grid_we    = 1'b1;
                grid_wdata = {1'b0, pc_reg};
                piece_we   = 1'b1;
                state_next = S_IDLE;
                done_next  = 1'b1;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res.status       = status_reg;
        res.found_piece  = $signed(found_reg);
        res.found_row    = frow_reg;
        res.found_col    = fcol_reg;
        res.placed_count = count_reg;
        if (cfg.fixed)
        begin
            res.box_top    = 5'd1;
            res.box_left   = 5'd1;
            res.box_bottom = cfg.rows;
            res.box_right  = cfg.cols;
        end
        else
        begin
            res.box_top    = top_reg;
            res.box_left   = left_reg;
            res.box_bottom = bottom_reg;
            res.box_right  = right_reg;
        end
    end

`ifndef NO_ASSERTIONS
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held longer than one cycle");

    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy))
        else $error("result strobe without a request in flight");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |-> ($past(state_reg) == S_PLACE)
                                && (count_reg == $past(count_reg) + 9'd1))
        else $error("placed count moved outside a placement");

    a_grid_write_src: assert property (@(posedge clk) disable iff (!rst_n)
        grid_we |-> (state_reg == S_CLEAR || state_reg == S_PLACE
                     || state_reg == S_SW2 || state_reg == S_SW3))
        else $error("grid write from an unexpected state");
`endif

endmodule

// ----- sv/placement_grid_window_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// placement_grid_window_table
// Piece placement grid of 2R x 2C cells with a reverse piece map, placed
// count and growing bounding box; APB configuration of R, C and window mode.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its result appears
// for one cycle with done high and cannot be held off. After reset the grid
// RAM is swept empty, one cell per cycle, over all
// 2**($clog2(2*MAX_ROWS)+$clog2(2*MAX_COLS)) cells (1024 at the defaults);
// busy stays high meanwhile, while APB writes are taken as usual. As busy
// drops together with done, the next request can be taken while done is high.
// Requests stopped by their first checks, a swap of a piece with itself and
// unused op codes end in S_EXEC; place (also when the cell is occupied) runs
// S_EXEC, S_PLACE; locate S_EXEC, S_LOC; cell read S_EXEC, S_CELL; cell
// neighbour S_EXEC, S_NBR, S_CELL; piece neighbour S_EXEC, S_PLOAD, S_NBR,
// S_CELL; swap S_EXEC, S_SW1, S_SW2, S_SW3. A neighbour request whose cell
// checks fail ends in S_NBR. The sequence is set by the single-port grid and
// piece map RAMs with registered read data: each dependent read or write
// takes its own state.
// ----------------------------------------------------------------------------
module placement_grid_window_table
    import pgw_pkg::*;
#(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              start,
    output logic              busy,
    input  logic [2:0]        op,
    input  logic [4:0]        row,
    input  logic [4:0]        col,
    input  logic [7:0]        piece,
    input  logic [7:0]        other_piece,
    input  logic [1:0]        direction,
    output logic              done,
    output logic [2:0]        status,
    output logic signed [8:0] found_piece,
    output logic [4:0]        found_row,
    output logic [4:0]        found_col,
    output logic [8:0]        placed_count,
    output logic [4:0]        box_top,
    output logic [4:0]        box_left,
    output logic [4:0]        box_bottom,
    output logic [4:0]        box_right
);

    localparam int GAW = $clog2(2*MAX_ROWS) + $clog2(2*MAX_COLS);

    cfg_t           cfg;
    res_t           res;
    logic           grid_we;
    logic           grid_re;
    logic [GAW-1:0] grid_addr;
    logic [8:0]     grid_wdata;
    logic [8:0]     grid_rdata;
    logic           piece_we;
    logic           piece_re;
    logic [7:0]     piece_addr;
    logic [GAW-1:0] piece_wdata;
    logic [GAW-1:0] piece_rdata;

    pgw_regs #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pgw_ram #(
        .DW (9),
        .AW (GAW)
    ) u_grid_ram (
        .clk   (clk),
        .we    (grid_we),
        .re    (grid_re),
        .addr  (grid_addr),
        .wdata (grid_wdata),
        .rdata (grid_rdata)
    );

    pgw_ram #(
        .DW (GAW),
        .AW (8)
    ) u_piece_ram (
        .clk   (clk),
        .we    (piece_we),
        .re    (piece_re),
        .addr  (piece_addr),
        .wdata (piece_wdata),
        .rdata (piece_rdata)
    );

    pgw_core #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .start       (start),
        .busy        (busy),
        .op          (op),
        .row         (row),
        .col         (col),
        .piece       (piece),
        .other_piece (other_piece),
        .direction   (direction),
        .done        (done),
        .res         (res),
        .grid_we     (grid_we),
        .grid_re     (grid_re),
        .grid_addr   (grid_addr),
        .grid_wdata  (grid_wdata),
        .grid_rdata  (grid_rdata),
        .piece_we    (piece_we),
        .piece_re    (piece_re),
        .piece_addr  (piece_addr),
        .piece_wdata (piece_wdata),
        .piece_rdata (piece_rdata)
    );

    assign status       = res.status;
    assign found_piece  = res.found_piece;
    assign found_row    = res.found_row;
    assign found_col    = res.found_col;
    assign placed_count = res.placed_count;
    assign box_top      = res.box_top;
    assign box_left     = res.box_left;
    assign box_bottom   = res.box_bottom;
    assign box_right    = res.box_right;

endmodule
